[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[sv/ipv6p_pkg.sv]
// ----------------------------------------------------------------------------
// ipv6p_pkg
// Types, constants and the hex digit decoder shared by the address parser.
// ----------------------------------------------------------------------------
package ipv6p_pkg;

  localparam int NUM_GROUPS = 8;
  localparam int MAX_DIGITS = 4;
  localparam int CNT_W      = 4;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  typedef enum logic [4:0] {
    PH_START      = 5'b00001,
    PH_LEAD_COLON = 5'b00010,
    PH_IN_GROUP   = 5'b00100,
    PH_ONE_COLON  = 5'b01000,
    PH_AFTER_GAP  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  // Finished string, handed from the parser to the expansion stage
  typedef struct packed {
    logic                         ok;
    logic                         gap_seen;
    logic [CNT_W-1:0]             gap_pos;
    logic [CNT_W-1:0]             count;
    logic [NUM_GROUPS-1:0][15:0]  groups;
  } fin_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = '0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

[sv/ipv6p_parser.sv]
// ----------------------------------------------------------------------------
// ipv6p_parser
// Input register and per-character parse state. On the last character the
// closed group list, gap position and validity are loaded into the
// finished-string register and the parse state starts over.
// ----------------------------------------------------------------------------
module ipv6p_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_code,
  input  logic              last,
  output logic              fin_valid,
  input  logic              fin_ready,
  output ipv6p_pkg::fin_t   fin
);
  import ipv6p_pkg::*;
  `include "assert_macros.svh"

  localparam logic [CNT_W-1:0] GROUP_LIMIT = CNT_W'(NUM_GROUPS);

  // input register
  logic       iv;
  logic [7:0] ichar;
  logic       ilast;

  // parse state
  phase_t                      phase, phase_next;
  logic [CNT_W-1:0]            count, count_next;
  logic [CNT_W-1:0]            gap_pos, gap_pos_next;
  logic                        gap_seen, gap_seen_next;
  logic [15:0]                 value, value_next;
  logic [2:0]                  digits, digits_next;
  logic                        failed, failed_next;
  logic [NUM_GROUPS-1:0][15:0] groups, groups_next;

  hex_t  hx;
  logic  is_colon;
  logic  begin_ok;
  logic  adv;
  logic  fin_free;
  fin_t  fin_d;

  assign fin_free = !fin_valid || fin_ready;
  assign adv      = iv && (!ilast || fin_free);
  assign in_ready = !iv || adv;

  always_comb begin
    phase_next    = phase;
    count_next    = count;
    gap_pos_next  = gap_pos;
    gap_seen_next = gap_seen;
    value_next    = value;
    digits_next   = digits;
    failed_next   = failed;
    groups_next   = groups;
    hx            = hex_decode(ichar);
    is_colon      = (ichar == CHAR_COLON);
    begin_ok      = (count < GROUP_LIMIT) && hx.is_hex;

    if (!failed) begin
      case (phase)
        PH_START: begin
          if (is_colon) begin
            phase_next = PH_LEAD_COLON;
          end else if (begin_ok) begin
            value_next  = {12'd0, hx.value};
            digits_next = 3'd1;
            phase_next  = PH_IN_GROUP;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_LEAD_COLON: begin
          if (is_colon) begin
            gap_seen_next = 1'b1;
            gap_pos_next  = '0;
            phase_next    = PH_AFTER_GAP;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_IN_GROUP: begin
          if (is_colon) begin
            groups_next[count[2:0]] = value;
            count_next  = count + 1'b1;
            value_next  = '0;
            digits_next = '0;
            phase_next  = PH_ONE_COLON;
          end else if (!hx.is_hex || digits >= 3'(MAX_DIGITS)) begin
            failed_next = 1'b1;
          end else begin
            value_next  = {value[11:0], hx.value};
            digits_next = digits + 1'b1;
          end
        end
        PH_ONE_COLON: begin
          if (is_colon) begin
            if (gap_seen) begin
              failed_next = 1'b1;
            end else begin
              gap_seen_next = 1'b1;
              gap_pos_next  = count;
              phase_next    = PH_AFTER_GAP;
            end
          end else if (begin_ok) begin
            value_next  = {12'd0, hx.value};
            digits_next = 3'd1;
            phase_next  = PH_IN_GROUP;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_AFTER_GAP: begin
          if (begin_ok) begin
            value_next  = {12'd0, hx.value};
            digits_next = 3'd1;
            phase_next  = PH_IN_GROUP;
          end else begin
            failed_next = 1'b1;
          end
        end
        default: begin
          failed_next = 1'b1;
        end
      endcase
    end
  end

  // end-of-string check; an open group is closed here
  always_comb begin
    fin_d.ok       = !failed_next;
    fin_d.gap_seen = gap_seen_next;
    fin_d.gap_pos  = gap_pos_next;
    fin_d.count    = count_next;
    fin_d.groups   = groups_next;
    if (phase_next == PH_IN_GROUP) begin
      fin_d.groups[count_next[2:0]] = value_next;
      fin_d.count = count_next + 1'b1;
    end else if (phase_next != PH_AFTER_GAP) begin
      fin_d.ok = 1'b0;
    end
    if (!gap_seen_next && fin_d.count != GROUP_LIMIT) begin
      fin_d.ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_ready) begin
      iv <= in_valid;
    end
    if (in_ready && in_valid) begin
      ichar <= char_code;
      ilast <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      count    <= '0;
      gap_pos  <= '0;
      gap_seen <= 1'b0;
      value    <= '0;
      digits   <= '0;
      failed   <= 1'b0;
    end else if (adv) begin
      if (ilast) begin
        phase    <= PH_START;
        count    <= '0;
        gap_pos  <= '0;
        gap_seen <= 1'b0;
        value    <= '0;
        digits   <= '0;
        failed   <= 1'b0;
      end else begin
        phase    <= phase_next;
        count    <= count_next;
        gap_pos  <= gap_pos_next;
        gap_seen <= gap_seen_next;
        value    <= value_next;
        digits   <= digits_next;
        failed   <= failed_next;
      end
    end
  end

  // only entries below count are ever read, so no clearing
  always_ff @(posedge clk) begin
    if (adv && !ilast) begin
      groups <= groups_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv && ilast) begin
      fin_valid <= 1'b1;
    end else if (fin_ready) begin
      fin_valid <= 1'b0;
    end
    if (adv && ilast) begin
      fin <= fin_d;
    end
  end

  `ASSERT_NEVER(a_count_range, count > GROUP_LIMIT, "group count above eight")
  `ASSERT_AT(a_digits_in_group,
    (phase == PH_IN_GROUP && !failed) |-> (digits != 3'd0 && digits <= 3'(MAX_DIGITS)),
    "digit count out of range inside a group")
  `ASSERT_AT(a_fin_ok_shape,
    (fin_valid && fin.ok) |-> (fin.count == GROUP_LIMIT || fin.gap_seen),
    "valid result without eight groups or a gap")
  `ASSERT_AT(a_gap_pos_clear, !gap_seen |-> (gap_pos == '0), "gap position set without a gap")

endmodule

[sv/ipv6p_expand.sv]
// ----------------------------------------------------------------------------
// ipv6p_expand
// Spreads the collected groups around the double-colon gap into eight
// words and registers the 128-bit result.
// ----------------------------------------------------------------------------
module ipv6p_expand (
  input  logic              clk,
  input  logic              rst,
  input  logic              fin_valid,
  output logic              fin_ready,
  input  ipv6p_pkg::fin_t   fin,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic [63:0]       addr_high,
  output logic [63:0]       addr_low
);
  import ipv6p_pkg::*;
  `include "assert_macros.svh"

  logic [CNT_W-1:0]            zeros;
  logic [CNT_W-1:0]            gp;
  logic [CNT_W:0]              gap_end;
  logic [NUM_GROUPS-1:0][15:0] words;

  assign fin_ready = !out_valid || out_ready;

  always_comb begin
    zeros   = CNT_W'(NUM_GROUPS) - fin.count;
    gp      = fin.gap_seen ? fin.gap_pos : CNT_W'(NUM_GROUPS);
    gap_end = {1'b0, gp} + {1'b0, zeros};
    for (int j = 0; j < NUM_GROUPS; j++) begin
      // words are numbered from the bottom: word 7 is the first group
      if ((CNT_W+1)'(j) < {1'b0, gp}) begin
        words[NUM_GROUPS-1-j] = fin.groups[j];
      end else if ((CNT_W+1)'(j) >= gap_end) begin
        words[NUM_GROUPS-1-j] = fin.groups[3'(j) - zeros[2:0]];
      end else begin
        words[NUM_GROUPS-1-j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_ready) begin
      out_valid <= fin_valid;
    end
    if (fin_valid && fin_ready) begin
      ok        <= fin.ok;
      addr_high <= fin.ok ? words[NUM_GROUPS-1:NUM_GROUPS/2] : '0;
      addr_low  <= fin.ok ? words[NUM_GROUPS/2-1:0] : '0;
    end
  end

  `ASSERT_AT(a_load_shows, (fin_valid && fin_ready) |=> out_valid,
    "finished string not presented")
  `ASSERT_AT(a_bad_is_zero, (out_valid && !ok) |-> (addr_high == '0 && addr_low == '0),
    "invalid result with nonzero address")
  `ASSERT_AT(a_full_identity,
    (fin_valid && fin_ready && fin.ok && fin.count == CNT_W'(NUM_GROUPS))
      |=> (addr_high[63:48] == $past(fin.groups[0]) &&
           addr_low[15:0] == $past(fin.groups[NUM_GROUPS-1])),
    "eight groups not passed straight through")

endmodule

[sv/ipv6_text_address_parser.sv]
// ----------------------------------------------------------------------------
// ipv6_text_address_parser
// Streaming parser for IPv6 address text: one character per item, one result
// per string.
// ----------------------------------------------------------------------------
// Accepts one character every clock cycle while in_ready is high, strings
// back to back. A result item is produced only for the character flagged
// last: ok plus the 128-bit address (zero when the text is not a valid
// address). An accepted last character moves its result from the input
// register through the parse state update and end-of-string check into the
// finished-string register, then through gap expansion into the output
// register. A stalled output holds the finished-string register, and a full
// one holds a last character back, so out_ready low backs up to in_ready.
module ipv6_text_address_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [63:0] addr_high,
  output logic [63:0] addr_low
);
  import ipv6p_pkg::*;

  logic fin_valid;
  logic fin_ready;
  fin_t fin;

  ipv6p_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .last      (last),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  ipv6p_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .addr_high (addr_high),
    .addr_low  (addr_low)
  );

endmodule

[verif/ipv6_text_address_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_tb
// Self-checking bench for the streaming IPv6 text address parser. A short
// table of strings exercises the error rules and edge characters, then random
// strings (mostly well formed, some damaged, some noise) run under several
// idle and stall mixes. Results match the software parse or a typed row.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_tb;
  import ipv6p_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 450;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_DIR      = 25;

  typedef struct packed {
    logic        ok;
    logic [63:0] hi;
    logic [63:0] lo;
  } addr_result_t;

  // one character per row; typed rows carry the expected result directly
  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic        typed;
    logic        ok;
    logic [63:0] hi;
    logic [63:0] lo;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // "::" -> all-zero address
    '{CHAR_COLON, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{CHAR_COLON, 1'b1, 1'b1, 1'b1, 64'h0, 64'h0},
    // byte values FF and 01 are bad characters
    '{8'hFF,      1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
    '{8'h01,      1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
    // single leading colon
    '{CHAR_COLON, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{"1",        1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
    // single trailing colon
    '{"1",        1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{CHAR_COLON, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
    // five digits in one group
    '{"f",        1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{"F",        1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{"a",        1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{"9",        1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{"0",        1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
    // ":::" -> empty group after the gap
    '{CHAR_COLON, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{CHAR_COLON, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{CHAR_COLON, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
    // "1::" trailing gap, accepted
    '{"1",        1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{CHAR_COLON, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{CHAR_COLON, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    // "::1::" second gap
    '{CHAR_COLON, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{CHAR_COLON, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{"1",        1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{CHAR_COLON, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{CHAR_COLON, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
    // "1": one group, no gap
    '{"1",        1'b1, 1'b1, 1'b0, 64'h0, 64'h0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = 8'h0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ok;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  ipv6_text_address_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .addr_high (addr_high),
    .addr_low  (addr_low)
  );

  always #1 clk = ~clk;

  addr_result_t pending_addrs[$];
  logic [7:0]   text_q[$];
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           mismatches     = 0;
  int           cycles         = 0;
  int           n_items        = 0;
  int           n_strings      = 0;
  int           n_results      = 0;
  int           n_valid        = 0;

  // --------------------------------------------------------------------------
  // Software parse state
  // --------------------------------------------------------------------------
  logic [15:0] sw_groups [NUM_GROUPS];
  int          sw_count;
  int          sw_gap_pos;
  bit          sw_gap_seen;
  logic [15:0] sw_value;
  int          sw_digits;
  phase_t      sw_phase;
  bit          sw_failed;

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_parse();
    foreach (sw_groups[i]) sw_groups[i] = 16'h0;
    sw_count    = 0;
    sw_gap_pos  = 0;
    sw_gap_seen = 1'b0;
    sw_value    = 16'h0;
    sw_digits   = 0;
    sw_phase    = PH_START;
    sw_failed   = 1'b0;
  endfunction

  function automatic void open_group(input logic [7:0] c);
    logic [3:0] v;
    if (sw_count >= NUM_GROUPS || !hex_nibble(c, v)) begin
      sw_failed = 1'b1;
      return;
    end
    sw_value  = {12'h0, v};
    sw_digits = 1;
    sw_phase  = PH_IN_GROUP;
  endfunction

  function automatic void close_group();
    sw_groups[sw_count % NUM_GROUPS] = sw_value;
    sw_count++;
    sw_value  = 16'h0;
    sw_digits = 0;
  endfunction

  // Advance the parse by one character; returns 1 when a result item is due.
  function automatic bit parse_char(input logic [7:0] c, input logic fin,
                                    output addr_result_t r);
    logic [15:0] words [NUM_GROUPS];
    logic [3:0]  v;
    bit          good;
    int          zeros;
    int          gp;
    int          dst;
    r = '0;
    if (!sw_failed) begin
      case (sw_phase)
        PH_START: begin
          if (c == CHAR_COLON) sw_phase = PH_LEAD_COLON;
          else open_group(c);
        end
        PH_LEAD_COLON: begin
          if (c == CHAR_COLON) begin
            sw_gap_seen = 1'b1;
            sw_gap_pos  = 0;
            sw_phase    = PH_AFTER_GAP;
          end else begin
            sw_failed = 1'b1;
          end
        end
        PH_IN_GROUP: begin
          if (c == CHAR_COLON) begin
            close_group();
            sw_phase = PH_ONE_COLON;
          end else if (!hex_nibble(c, v) || sw_digits >= MAX_DIGITS) begin
            sw_failed = 1'b1;
          end else begin
            sw_value = {sw_value[11:0], v};
            sw_digits++;
          end
        end
        PH_ONE_COLON: begin
          if (c == CHAR_COLON) begin
            if (sw_gap_seen) begin
              sw_failed = 1'b1;
            end else begin
              sw_gap_seen = 1'b1;
              sw_gap_pos  = sw_count;
              sw_phase    = PH_AFTER_GAP;
            end
          end else begin
            open_group(c);
          end
        end
        PH_AFTER_GAP: open_group(c);
        default: sw_failed = 1'b1;
      endcase
    end
    if (!fin) return 1'b0;

    good = !sw_failed;
    if (good) begin
      if (sw_phase == PH_IN_GROUP) close_group();
      else if (sw_phase != PH_AFTER_GAP) good = 1'b0;
    end
    if (good && !sw_gap_seen && sw_count != NUM_GROUPS) good = 1'b0;
    if (good && sw_count > NUM_GROUPS) good = 1'b0;

    if (good) begin
      foreach (words[i]) words[i] = 16'h0;
      zeros = NUM_GROUPS - sw_count;
      gp    = sw_gap_seen ? sw_gap_pos : NUM_GROUPS;
      for (int i = 0; i < sw_count && i < NUM_GROUPS; i++) begin
        dst = (i >= gp) ? i + zeros : i;
        words[dst % NUM_GROUPS] = sw_groups[i];
      end
      r.ok = 1'b1;
      r.hi = {words[0], words[1], words[2], words[3]};
      r.lo = {words[4], words[5], words[6], words[7]};
    end
    clear_parse();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Random text
  // --------------------------------------------------------------------------
  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(3))
      0:       return CHAR_COLON;
      1:       return hex_char();
      default: return 8'($urandom_range(255, 1));
    endcase
  endfunction

  // Mostly well-formed addresses; a share with wrong group counts or long
  // groups, a share with one damaged character, and some plain noise.
  task automatic make_string();
    int kind;
    int ngroups;
    int gap_at;
    int nd;
    int pos;
    bit use_gap;
    text_q.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(12, 1)) text_q.push_back(noise_char());
      return;
    end
    use_gap = $urandom_range(1);
    if (use_gap) ngroups = $urandom_range(kind < 35 ? 9 : 8, 0);
    else ngroups = (kind < 35) ? $urandom_range(9, 1) : NUM_GROUPS;
    gap_at = $urandom_range(ngroups);
    for (int g = 0; g <= ngroups; g++) begin
      if (use_gap && g == gap_at) begin
        text_q.push_back(CHAR_COLON);
        text_q.push_back(CHAR_COLON);
      end else if (g > 0 && g < ngroups) begin
        text_q.push_back(CHAR_COLON);
      end
      if (g < ngroups) begin
        nd = (kind < 35 && $urandom_range(7) == 0) ? 5 : $urandom_range(4, 1);
        repeat (nd) text_q.push_back(hex_char());
      end
    end
    if (kind < 25) begin
      pos = $urandom_range(text_q.size() - 1);
      case ($urandom_range(3))
        0:       text_q[pos] = noise_char();
        1:       text_q.insert(pos, CHAR_COLON);
        2:       text_q.insert(pos, hex_char());
        default: if (text_q.size() > 1) text_q.delete(pos);
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last      <= fin;
    do @(posedge clk); while (!in_ready);
    n_items++;
  endtask

  // hold off input until every outstanding result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    addr_result_t want;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_addrs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result item with none expected: ok=%0b hi=%h lo=%h",
                   ok, addr_high, addr_low);
      end else begin
        want = pending_addrs.pop_front();
        if (want.ok) n_valid++;
        if (ok !== want.ok || addr_high !== want.hi || addr_low !== want.lo) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected ok=%0b hi=%h lo=%h, got ok=%0b hi=%h lo=%h",
                     want.ok, want.hi, want.lo, ok, addr_high, addr_low);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    addr_result_t r;
    int           sent;
    clear_parse();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling
    foreach (DIR_ROWS[i]) begin
      send_char(DIR_ROWS[i].ch, DIR_ROWS[i].fin);
      if (parse_char(DIR_ROWS[i].ch, DIR_ROWS[i].fin, r)) begin
        if (DIR_ROWS[i].typed) r = '{DIR_ROWS[i].ok, DIR_ROWS[i].hi, DIR_ROWS[i].lo};
        pending_addrs.push_back(r);
        n_strings++;
      end
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        make_string();
        for (int i = 0; i < text_q.size(); i++) begin
          send_char(text_q[i], i == text_q.size() - 1);
          if (parse_char(text_q[i], i == text_q.size() - 1, r))
            pending_addrs.push_back(r);
          sent++;
        end
        n_strings++;
      end
      drain();
    end

    mismatches += pending_addrs.size();
    $display("Parsed %0d strings from %0d characters under four idle/stall mixes;",
             n_strings, n_items);
    $display("%0d result items checked, %0d of them valid addresses.", n_results, n_valid);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
